@@ rtl/kdcc_pkg.sv @@
// Shared types and constants for the key debounce and click classifier.
package kdcc_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int KEY_W     = 4;
  localparam int CNT_W     = 16;
  localparam int KEYS_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_BOUNCE   = 2'd1,
    PH_HELD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_COMBO        = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_RELEASE      = 3'd4,
    EV_LONG_RELEASE = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYS_IN_USE        = 2'd0,
    REG_LONG_INTERVAL      = 2'd1,
    REG_DEBOUNCE_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   held_ticks;
    logic [CNT_W-1:0]   quiet_ticks;
    logic [CNT_W-1:0]   press_count;
    logic [CNT_W-1:0]   release_count;
  } key_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_interval;
    logic [CNT_W-1:0] debounce_threshold;
  } kdcc_cfg_t;

  localparam key_state_t KEY_STATE_RESET = '{
    phase:         PH_IDLE,
    held_ticks:    '0,
    quiet_ticks:   '0,
    press_count:   '0,
    release_count: '0
  };

endpackage

@@ rtl/key_debounce_click_classifier.sv @@
// Top level: key debounce and click classifier over a per-key state RAM.
//
// Each input transaction carries one tick sample (key index, pressed level)
// and yields exactly one output transaction: the key, an event code (none,
// press, combo, long press, release, long release) and the key's running
// press count. Samples for keys at or above keys_in_use give event none and
// count zero and leave the key untouched. Throughput is one transaction per
// clock while out_stall does not hold the output; a sample is registered in
// stage 1 and then in the output register, which drives out_valid. The per-key
// state lives in a 16-entry RAM with registered read: stage 0 reads the entry,
// stage 1 updates it and writes it back while loading the output register.
// A sample for the key updated in the cycle before is served from a bypass
// register instead of the RAM. Each entry has a valid flop cleared by reset,
// so every key starts idle with zero counters and no clearing pass is needed.
// Configuration writes are expected only while no transaction is in flight.
module key_debounce_click_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kdcc_pkg::KEY_W-1:0]     in_key_index,
  input  logic                           in_pressed,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kdcc_pkg::KEY_W-1:0]     out_event_key,
  output logic [2:0]                     out_event_code,
  output logic [kdcc_pkg::CNT_W-1:0]     out_combo_count,
  // configuration
  input  logic                           cfg_we,
  input  logic [kdcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdcc_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  // configuration registers
  logic [kdcc_pkg::KEYS_W-1:0] keys_in_use_r;
  kdcc_pkg::kdcc_cfg_t         cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_in_use_r                <= '0;
      cfg_r.long_interval          <= 16'd100;
      cfg_r.debounce_threshold     <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdcc_pkg::REG_KEYS_IN_USE:
          keys_in_use_r <= cfg_wdata[kdcc_pkg::KEYS_W-1:0];
        kdcc_pkg::REG_LONG_INTERVAL:
          cfg_r.long_interval <= cfg_wdata;
        kdcc_pkg::REG_DEBOUNCE_THRESHOLD:
          cfg_r.debounce_threshold <= cfg_wdata;
        default: ;  // unused index: ignored
      endcase
    end
  end

  // handshake
  logic in_accept;
  logic out_free;
  logic s1_valid_r;
  logic s1_fire;
  logic out_valid_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && out_free;

  // stage 1 transaction fields
  logic [kdcc_pkg::KEY_W-1:0] s1_key_r;
  logic                       s1_pressed_r;
  logic                       rd_valid_r;
  logic                       bypass_hit_r;
  kdcc_pkg::key_state_t       bypass_state_r;

  // state RAM
  logic                       ram_we;
  kdcc_pkg::key_state_t       ram_rdata;
  kdcc_pkg::key_state_t       s1_cur;
  kdcc_pkg::key_state_t       s1_nxt;
  kdcc_pkg::event_t           s1_ev;
  logic [kdcc_pkg::CNT_W-1:0] s1_count;
  logic                       s1_scanned;
  logic [kdcc_pkg::MAX_KEYS-1:0] entry_valid_r;

  kdcc_ram #(
    .WIDTH ($bits(kdcc_pkg::key_state_t)),
    .DEPTH (kdcc_pkg::MAX_KEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_key_r),
    .wdata (s1_nxt),
    .re    (in_accept),
    .raddr (in_key_index),
    .rdata (ram_rdata)
  );

  assign s1_scanned = {1'b0, s1_key_r} < keys_in_use_r;
  assign ram_we     = s1_fire && s1_scanned;

  // bypass beats RAM; an entry never written reads as the reset state
  always_comb begin
    priority if (bypass_hit_r) s1_cur = bypass_state_r;
    else if (rd_valid_r)       s1_cur = ram_rdata;
    else                       s1_cur = kdcc_pkg::KEY_STATE_RESET;
  end

  kdcc_update u_update (
    .cur         (s1_cur),
    .pressed     (s1_pressed_r),
    .scanned     (s1_scanned),
    .cfg         (cfg_r),
    .nxt         (s1_nxt),
    .ev          (s1_ev),
    .combo_count (s1_count)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      bypass_hit_r <= 1'b0;
      rd_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r   <= 1'b1;
        // read and write to one key at the same edge: RAM gives old data
        bypass_hit_r <= ram_we && (s1_key_r == in_key_index);
        rd_valid_r   <= entry_valid_r[in_key_index];
      end else if (s1_fire) begin
        s1_valid_r   <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_key_r       <= in_key_index;
      s1_pressed_r   <= in_pressed;
      bypass_state_r <= s1_nxt;
    end
  end

  // entry valid flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (ram_we) begin
      entry_valid_r[s1_key_r] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event_key   <= s1_key_r;
      out_event_code  <= s1_ev;
      out_combo_count <= s1_count;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // backpressure only while stage 1 holds a transaction
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty stage 1");

  // a state write comes only from a transaction leaving stage 1
  a_write_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (s1_valid_r && out_free))
    else $error("state write without stage 1 advance");

  // bypass is only selected after a write to the same key
  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !(ram_we && s1_key_r == in_key_index)) |=> !bypass_hit_r)
    else $error("bypass selected without matching write");

  // a first press always reports a count of one
  a_press_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_code == kdcc_pkg::EV_PRESS) |-> (out_combo_count == 16'd1))
    else $error("press event with count other than one");
`endif

endmodule

@@ rtl/kdcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kdcc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/kdcc_update.sv @@
// Per-key phase machine: next state, event and combo count for one sample.
module kdcc_update (
  input  kdcc_pkg::key_state_t cur,
  input  logic                 pressed,
  input  logic                 scanned,
  input  kdcc_pkg::kdcc_cfg_t  cfg,
  output kdcc_pkg::key_state_t nxt,
  output kdcc_pkg::event_t     ev,
  output logic [kdcc_pkg::CNT_W-1:0] combo_count
);

  logic [kdcc_pkg::CNT_W-1:0] held_inc;
  logic [kdcc_pkg::CNT_W-1:0] quiet_inc;
  logic [kdcc_pkg::CNT_W-1:0] press_inc;
  logic [kdcc_pkg::CNT_W-1:0] release_inc;
  logic                       debounced;
  logic                       long_held;
  kdcc_pkg::phase_t           phase_nxt;

  assign held_inc    = cur.held_ticks + 1'b1;
  assign quiet_inc   = cur.quiet_ticks + 1'b1;
  assign press_inc   = cur.press_count + 1'b1;
  assign release_inc = cur.release_count + 1'b1;
  assign debounced   = held_inc > cfg.debounce_threshold;
  assign long_held   = cur.held_ticks >= cfg.long_interval;

  // next phase
  always_comb begin
    phase_nxt = cur.phase;
    unique case (cur.phase)
      kdcc_pkg::PH_IDLE: begin
        if (pressed) phase_nxt = kdcc_pkg::PH_BOUNCE;
      end
      kdcc_pkg::PH_BOUNCE: begin
        if (!pressed)      phase_nxt = kdcc_pkg::PH_IDLE;
        else if (debounced) phase_nxt = kdcc_pkg::PH_HELD;
      end
      kdcc_pkg::PH_HELD: begin
        if (!pressed) phase_nxt = kdcc_pkg::PH_RELEASED;
      end
      kdcc_pkg::PH_RELEASED: begin
        priority if (long_held)                      phase_nxt = kdcc_pkg::PH_IDLE;
        else if (pressed)                            phase_nxt = kdcc_pkg::PH_BOUNCE;
        else if (quiet_inc == cfg.long_interval)     phase_nxt = kdcc_pkg::PH_IDLE;
      end
      default: phase_nxt = cur.phase;
    endcase
  end

  // counters and event
  always_comb begin
    nxt       = cur;
    nxt.phase = phase_nxt;
    ev        = kdcc_pkg::EV_NONE;
    unique case (cur.phase)
      kdcc_pkg::PH_IDLE: begin
        if (pressed) begin
          nxt.held_ticks    = '0;
          nxt.quiet_ticks   = '0;
          nxt.press_count   = '0;
          nxt.release_count = '0;
        end
      end
      kdcc_pkg::PH_BOUNCE: begin
        if (pressed) begin
          nxt.held_ticks = held_inc;
          if (debounced) begin
            nxt.press_count = press_inc;
            // a wrapped count of zero reports nothing
            if (press_inc == 16'd1)     ev = kdcc_pkg::EV_PRESS;
            else if (press_inc != '0)   ev = kdcc_pkg::EV_COMBO;
          end
        end
      end
      kdcc_pkg::PH_HELD: begin
        if (pressed) begin
          nxt.held_ticks = held_inc;
          if (held_inc == cfg.long_interval) ev = kdcc_pkg::EV_LONG_PRESS;
        end else begin
          nxt.release_count = release_inc;
        end
      end
      kdcc_pkg::PH_RELEASED: begin
        if (long_held) begin
          ev = kdcc_pkg::EV_LONG_RELEASE;
        end else if (pressed) begin
          nxt.held_ticks  = '0;
          nxt.quiet_ticks = '0;
        end else begin
          nxt.quiet_ticks = quiet_inc;
          if (quiet_inc == cfg.long_interval && cur.release_count == 16'd1) begin
            ev = kdcc_pkg::EV_RELEASE;
          end
        end
      end
      default: ev = kdcc_pkg::EV_NONE;
    endcase
    if (!scanned) begin
      nxt = cur;
      ev  = kdcc_pkg::EV_NONE;
    end
  end

  assign combo_count = scanned ? nxt.press_count : '0;

endmodule
